// ----- rtl/rdp_pkg.sv -----
// ----------------------------------------------------------------------------
// rdp_pkg: shared constants and types for the refresh deadline pacer
// Holds the refresh rate, the period and fraction constants, and the
// fixed-point constants used to count missed periods without a divider.
// ----------------------------------------------------------------------------
package rdp_pkg;

	localparam int RATE_HZ = 24;
	localparam int RATE_W  = $clog2(RATE_HZ + 1);
	localparam int TIME_W  = 64;
	localparam int CNT_W   = 32;
	localparam int FRAC_W  = 10;
	localparam int ACC_W   = FRAC_W + 1;

	localparam logic [TIME_W-1:0] NS_PER_SEC = 64'd1000000000;
	localparam logic [TIME_W-1:0] PERIOD_NS  = NS_PER_SEC / 64'(RATE_HZ);
	localparam logic [FRAC_W-1:0] FRAC_STEP  = FRAC_W'(NS_PER_SEC % 64'(RATE_HZ));

	// Lateness at or above this value saturates the missed count.
	localparam logic [TIME_W-1:0] LATE_SAT =
		(64'hFFFF_FFFF * NS_PER_SEC + 64'(RATE_HZ) - 64'd1) / 64'(RATE_HZ);

	// One second is 2^DIV_SH times DIV_D nanoseconds.
	localparam int DIV_SH  = 9;
	localparam int D_W     = 21;
	localparam int Q_W     = 32;
	localparam int QSH     = 21;
	localparam int X_W     = QSH + Q_W;
	localparam int LATE_W  = X_W + DIV_SH;
	localparam int RECIP_W = 33;
	localparam int REM_W   = 23;

	localparam logic [D_W-1:0]     DIV_D = D_W'(NS_PER_SEC >> DIV_SH);
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((64'd1 << (QSH + Q_W)) / (NS_PER_SEC >> DIV_SH));
	localparam logic [REM_W-1:0]   DIV_D1 = REM_W'(NS_PER_SEC >> DIV_SH);
	localparam logic [REM_W-1:0]   DIV_D2 = REM_W'((NS_PER_SEC >> DIV_SH) * 2);
	localparam logic [REM_W-1:0]   DIV_D3 = REM_W'((NS_PER_SEC >> DIV_SH) * 3);
	localparam logic [REM_W-1:0]   DIV_D4 = REM_W'((NS_PER_SEC >> DIV_SH) * 4);

	typedef struct packed {
		logic              due;
		logic [TIME_W-1:0] late;
	} rdp_late_t;

endpackage

// ----- rtl/rdp_track.sv -----
// ----------------------------------------------------------------------------
// rdp_track: deadline tracking stage
// Registers each timestamp, compares it with the deadline, and on the first or a due
// word updates the deadline, the fraction accumulator and the armed flag as it moves on.
// ----------------------------------------------------------------------------
module rdp_track (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [63:0]               now_time_ns,
	output logic                      trk_valid,
	input  logic                      trk_ready,
	output rdp_pkg::rdp_late_t        trk_word
);
	import rdp_pkg::*;

	logic              v_s1;
	logic [TIME_W-1:0] now_s1;
	logic              v_s2;
	rdp_late_t         word_s2;
	logic [TIME_W-1:0] deadline_q;
	logic [FRAC_W-1:0] frac_q;
	logic              armed_q;
	logic              en_s1;
	logic              en_s2;
	logic              take;
	logic              due;
	logic [ACC_W-1:0]  acc;
	logic [FRAC_W-1:0] frac_nxt;
	logic [TIME_W-1:0] period;
	logic [TIME_W-1:0] late;

	assign en_s2    = !v_s2 || trk_ready;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign take     = v_s1 && en_s2;

	always_comb begin
		acc  = (armed_q ? {1'b0, frac_q} : ACC_W'(0)) + {1'b0, FRAC_STEP};
		due  = armed_q && (now_s1 >= deadline_q);
		late = now_s1 - deadline_q;
		if (acc >= ACC_W'(RATE_HZ)) begin
			frac_nxt = FRAC_W'(acc - ACC_W'(RATE_HZ));
			period   = PERIOD_NS + 64'd1;
		end else begin
			frac_nxt = acc[FRAC_W-1:0];
			period   = PERIOD_NS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			deadline_q <= '0;
			frac_q     <= '0;
			armed_q    <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (take && (!armed_q || due)) begin
				armed_q    <= 1'b1;
				frac_q     <= frac_nxt;
				deadline_q <= now_s1 + period;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			now_s1 <= now_time_ns;
		end
		if (en_s2) begin
			word_s2.due  <= due;
			word_s2.late <= late;
		end
	end

	assign trk_valid = v_s2;
	assign trk_word  = word_s2;

`ifndef ASSERT_OFF
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		frac_q < FRAC_W'(RATE_HZ))
		else $error("fraction accumulator reached the rate");

	a_arm_first: assert property (@(posedge clk) disable iff (!arst_n)
		take && !armed_q |=> armed_q)
		else $error("first word did not arm the pacer");

	a_armed_holds: assert property (@(posedge clk) disable iff (!arst_n)
		armed_q |=> armed_q)
		else $error("armed flag dropped without reset");

	a_early_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		take && armed_q && !due |=> $stable(deadline_q) && $stable(frac_q))
		else $error("early word changed the deadline state");
`endif

endmodule

// ----- rtl/rdp_miss.sv -----
// ----------------------------------------------------------------------------
// rdp_miss: missed period counter
// Four stages turn the lateness into whole missed periods: scale by the
// rate, estimate the quotient by a reciprocal, form the remainder, correct.
// ----------------------------------------------------------------------------
module rdp_miss (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  rdp_pkg::rdp_late_t        in_word,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      refresh_due,
	output logic [31:0]               missed_count
);
	import rdp_pkg::*;

	logic                        v_s3, v_s4, v_s5, v_s6;
	logic                        en_s3, en_s4, en_s5, en_s6;
	logic                        due_s3, due_s4, due_s5, due_s6;
	logic                        sat_s3, sat_s4, sat_s5;
	logic [X_W-1:0]              x_s3, x_s4;
	logic [Q_W-1:0]              qest_s4, qest_s5;
	logic [REM_W-1:0]            rem_s5;
	logic [CNT_W-1:0]            missed_s6;
	logic [LATE_W+RATE_W-1:0]    scaled;
	logic [Q_W+RECIP_W-1:0]      qprod;
	logic [Q_W+D_W-1:0]          qd;
	logic [REM_W-1:0]            rem;
	logic [Q_W-1:0]              qfix;

	assign en_s6    = !v_s6 || out_ready;
	assign en_s5    = !v_s5 || en_s6;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign in_ready = en_s3;

	always_comb begin
		scaled = {{RATE_W{1'b0}}, in_word.late[LATE_W-1:0]}
			* {{LATE_W{1'b0}}, RATE_W'(RATE_HZ)};
		qprod  = {{RECIP_W{1'b0}}, x_s3[X_W-1:QSH]} * {{Q_W{1'b0}}, RECIP};
		qd     = {{D_W{1'b0}}, qest_s4} * {{Q_W{1'b0}}, DIV_D};
		rem    = x_s4[REM_W-1:0] - qd[REM_W-1:0];
		qfix   = qest_s5 + Q_W'(rem_s5 >= DIV_D1) + Q_W'(rem_s5 >= DIV_D2)
			+ Q_W'(rem_s5 >= DIV_D3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= in_valid;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
			if (en_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			due_s3 <= in_word.due;
			sat_s3 <= in_word.late >= LATE_SAT;
			x_s3   <= scaled[LATE_W-1:DIV_SH];
		end
		if (en_s4) begin
			due_s4  <= due_s3;
			sat_s4  <= sat_s3;
			x_s4    <= x_s3;
			qest_s4 <= qprod[2*Q_W-1:Q_W];
		end
		if (en_s5) begin
			due_s5  <= due_s4;
			sat_s5  <= sat_s4;
			qest_s5 <= qest_s4;
			rem_s5  <= rem;
		end
		if (en_s6) begin
			due_s6 <= due_s5;
			if (!due_s5) begin
				missed_s6 <= '0;
			end else if (sat_s5) begin
				missed_s6 <= '1;
			end else begin
				missed_s6 <= qfix;
			end
		end
	end

	assign out_valid    = v_s6;
	assign refresh_due  = due_s6;
	assign missed_count = missed_s6;

`ifndef ASSERT_OFF
	a_no_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !refresh_due |-> missed_count == '0)
		else $error("missed count set without a refresh");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && due_s5 && !sat_s5 |-> rem_s5 < DIV_D4)
		else $error("quotient estimate out of correction range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> v_s3 && v_s4 && v_s5 && out_valid && !out_ready)
		else $error("counter stalled with a free stage");
`endif

endmodule

// ----- rtl/refresh_deadline_pacer.sv -----
// ----------------------------------------------------------------------------
// refresh_deadline_pacer: fixed-rate refresh pacing from nanosecond timestamps
// Each word passes through the tracking stages s1 and s2, then the counting stages s3 to s6.
// Throughput: one word per cycle; a stalled output backs up the six stages.
// The deadline compare and update sit in one stage, so words follow each other.
// Reset clears the deadline, the fraction and the armed flag and empties
// every stage; the first word after reset arms the pacer.
// ----------------------------------------------------------------------------
module refresh_deadline_pacer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] now_time_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        refresh_due,
	output logic [31:0] missed_count
);
	import rdp_pkg::*;

	logic      trk_valid;
	logic      trk_ready;
	rdp_late_t trk_word;

	rdp_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.now_time_ns (now_time_ns),
		.trk_valid   (trk_valid),
		.trk_ready   (trk_ready),
		.trk_word    (trk_word)
	);

	rdp_miss u_miss (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (trk_valid),
		.in_ready     (trk_ready),
		.in_word      (trk_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.refresh_due  (refresh_due),
		.missed_count (missed_count)
	);

endmodule
